// ===== hdl/fcs_pkg.sv =====
// Shared types, codes and constants of the framed command slave.
`timescale 1ns / 1ps
`default_nettype none
package fcs_pkg;

    // Info store geometry and response length
    localparam int INFO_BYTES     = 16;
    localparam int INFO_AW        = 4;
    localparam int WRITABLE_BYTES = 12;
    localparam int RESPONSE_LEN   = 6;

    // Stream payload widths
    localparam int S_TDATA_W = 24;  // rx_byte, sensor_reading, zero pad
    localparam int M_TDATA_W = 40;  // data_byte .. sensor_select, zero pad

    // Link characters
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] END_MARK = 8'hFF;
    localparam logic [7:0] CMD_COMMIT = 8'hFF;
    localparam logic [15:0] ATTEN_MARK = 16'h8000;

    // Operation codes in command bits 7:6
    localparam logic [1:0] OP_ATTEN = 2'd0;
    localparam logic [1:0] OP_SENSOR = 2'd1;
    localparam logic [1:0] OP_INFO  = 2'd2;
    localparam logic [1:0] OP_POWER = 2'd3;

    // Highest sensor code that starts a conversion
    localparam logic [3:0] SENSOR_MAX = 4'd4;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_TX     = 3'd0,
        KIND_ATTEN  = 3'd1,
        KIND_POWER  = 3'd2,
        KIND_COMMIT = 3'd3,
        KIND_SAMPLE = 3'd4
    } kind_t;

    // Response steps: step 0 is the operation result, 1..6 the ack bytes
    localparam logic [2:0] STEP_OP   = 3'd0;
    localparam logic [2:0] STEP_SYNC = 3'd1;
    localparam logic [2:0] STEP_S    = 3'd2;
    localparam logic [2:0] STEP_BANG = 3'd3;
    localparam logic [2:0] STEP_CMD  = 3'd4;
    localparam logic [2:0] STEP_ACK  = 3'd5;
    localparam logic [2:0] STEP_END  = 3'd6;

    // One response job handed from the controller to the response generator
    typedef struct packed {
        logic        op_vld;   // leading operation result present
        kind_t       op_kind;
        logic [2:0]  unit;
        logic [15:0] word;
        logic [7:0]  pwr;
        logic [2:0]  sel;
        logic        ack_vld;  // acknowledge bytes follow
        logic [7:0]  cmd;
        logic [7:0]  ack;
    } job_t;

    // Info store access, at most one per cycle
    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [INFO_AW-1:0] addr;
        logic [7:0]         wr_data;
    } mem_req_t;

    // Power-up contents of the info store
    function automatic logic [7:0] info_default(input logic [INFO_AW-1:0] addr);
        logic [7:0] val;
        unique case (addr)
            4'd9:    val = 8'h82;
            4'd12:   val = 8'h02;
            4'd14:   val = 8'h12;
            4'd15:   val = 8'h34;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/framed_command_slave_top.sv =====
// Top level of the framed command slave: controller, info store, responder.
// Timing: a frame end byte passes the input register and the responder's job register
// before its result leaves; an info read also waits on the info store read port.
// Throughput: one input transaction per cycle while no results are due; a
// frame end or returned reading occupies the responder until its results have left,
// one result transaction per cycle while m_tready is high.
// Reset: synchronous, active low; the info store reads its default table.
`timescale 1ns / 1ps
`default_nettype none
module framed_command_slave_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [7:0] rx_byte, [17:8] sensor_reading, [23:18] zero
    input  wire logic [fcs_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] command
    input  wire logic [0:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [7:0] data_byte, [10:8] unit_index, [26:11] attenuator_word,
    // [34:27] power_bits, [37:35] sensor_select, [39:38] zero
    output logic [fcs_pkg::M_TDATA_W-1:0]        m_tdata,
    // [2:0] kind
    output logic [2:0]                           m_tuser,
    output logic                                 m_tlast
);
    import fcs_pkg::*;

    logic     job_vld;
    logic     job_rdy;
    job_t     job;
    mem_req_t mem_req;
    logic [7:0] mem_rd_data;

    fcs_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .job_vld     (job_vld),
        .job         (job),
        .job_rdy     (job_rdy),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    fcs_info_mem u_info_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    fcs_resp u_resp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .job_vld  (job_vld),
        .job      (job),
        .job_rdy  (job_rdy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// ===== hdl/fcs_info_mem.sv =====
// Info store: 16 x 8 synchronous memory with power-up defaults via valid bits.
`timescale 1ns / 1ps
`default_nettype none
module fcs_info_mem (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire fcs_pkg::mem_req_t req,
    output logic [7:0]             rd_data
);
    import fcs_pkg::*;

    logic [7:0]            mem [INFO_BYTES];
    logic [INFO_BYTES-1:0] valid_reg;
    logic [7:0]            rd_mem_reg;
    logic                  rd_valid_reg;
    logic [7:0]            rd_dflt_reg;

    // Mark written entries; unwritten ones read as the default table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.addr] <= 1'b1;
        end
    end

    // Write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_mem_reg   <= mem[req.addr];
            rd_valid_reg <= valid_reg[req.addr];
            rd_dflt_reg  <= info_default(req.addr);
        end
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : rd_dflt_reg;

    // The controller never reads and writes in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        req.wr_en |-> !req.rd_en)
        else $error("info store read and write collide");

endmodule
`default_nettype wire

// ===== hdl/fcs_ctrl.sv =====
// Frame parser and command executor: input register, frame state, job issue.
`timescale 1ns / 1ps
`default_nettype none
module fcs_ctrl (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [fcs_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [0:0]                      s_tuser,
    output logic                                 job_vld,
    output fcs_pkg::job_t                        job,
    input  wire logic                            job_rdy,
    output fcs_pkg::mem_req_t                    mem_req,
    input  wire logic [7:0]                      mem_rd_data
);
    import fcs_pkg::*;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_CMD  = 4'b0010,
        PH_ARG  = 4'b0100,
        PH_END  = 4'b1000
    } phase_t;

    // Input register
    logic       in_vld_reg, in_vld_next;
    logic       in_flag_reg;
    logic [7:0] in_byte_reg;
    logic [9:0] in_rd_reg;

    // Frame and block state
    phase_t     phase_reg, phase_next;
    logic [1:0] pre_cnt_reg, pre_cnt_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] arg_reg, arg_next;
    logic [9:0] reading_reg, reading_next;
    logic [7:0] power_reg, power_next;
    logic       await_reg, await_next;
    logic       pend_rd_reg, pend_rd_next;

    // Decode of the held item
    logic       needs_job;
    logic       needs_rd;
    logic       wr_dec;
    job_t       dec_job;
    logic       consume;
    logic       frame_end;
    logic [1:0] op;
    logic [3:0] sub;
    logic [2:0] unit;
    logic [7:0] unit_mask;
    logic [7:0] power_upd;
    logic [7:0] pre_char;
    logic [1:0] pre_cnt_upd;

    assign op        = cmd_reg[7:6];
    assign sub       = cmd_reg[3:0];
    assign unit      = cmd_reg[2:0];
    assign unit_mask = 8'b1 << unit;
    assign power_upd = (arg_reg != 8'h00) ? (power_reg | unit_mask)
                                          : (power_reg & ~unit_mask);
    assign frame_end = !in_flag_reg && !await_reg && (phase_reg == PH_END)
                       && (in_byte_reg == END_MARK);

    // Decode the held item into a response job and a memory access
    always_comb begin
        needs_job = 1'b0;
        needs_rd  = 1'b0;
        wr_dec    = 1'b0;
        dec_job   = '0;
        dec_job.op_kind = KIND_TX;
        dec_job.cmd     = cmd_reg;
        if (in_flag_reg) begin
            if (await_reg) begin
                needs_job       = 1'b1;
                dec_job.ack_vld = 1'b1;
                dec_job.ack     = in_rd_reg[9:2];
            end
        end else if (frame_end) begin
            needs_job = 1'b1;
            if (cmd_reg == CMD_COMMIT) begin
                dec_job.op_vld  = 1'b1;
                dec_job.op_kind = KIND_COMMIT;
                dec_job.ack_vld = 1'b1;
            end else begin
                unique case (op)
                    OP_ATTEN: begin
                        dec_job.op_vld  = 1'b1;
                        dec_job.op_kind = KIND_ATTEN;
                        dec_job.unit    = unit;
                        dec_job.word    = ATTEN_MARK | {8'h00, arg_reg};
                        dec_job.ack_vld = 1'b1;
                    end
                    OP_SENSOR: begin
                        if (sub > SENSOR_MAX) begin
                            dec_job.ack_vld = 1'b1;
                            dec_job.ack     = {6'b0, reading_reg[1:0]};
                        end else begin
                            dec_job.op_vld  = 1'b1;
                            dec_job.op_kind = KIND_SAMPLE;
                            dec_job.sel     = sub[2:0];
                        end
                    end
                    OP_INFO: begin
                        dec_job.ack_vld = 1'b1;
                        if (cmd_reg[4] && ({1'b0, sub} < 5'(WRITABLE_BYTES))) begin
                            wr_dec      = 1'b1;
                            dec_job.ack = arg_reg;
                        end else begin
                            needs_rd = 1'b1;
                        end
                    end
                    OP_POWER: begin
                        dec_job.op_vld  = 1'b1;
                        dec_job.op_kind = KIND_POWER;
                        dec_job.pwr     = power_upd;
                        dec_job.ack_vld = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Take the held item when no read is pending and the job can be placed
    assign consume  = in_vld_reg && !pend_rd_reg && (!needs_job || job_rdy);
    assign s_tready = !in_vld_reg || consume;

    // Issue the job; a pending info read supplies its ack in the cycle after the read
    always_comb begin
        job_vld = pend_rd_reg || (consume && needs_job && !needs_rd);
        job     = dec_job;
        if (pend_rd_reg) begin
            job         = '0;
            job.op_kind = KIND_TX;
            job.ack_vld = 1'b1;
            job.cmd     = cmd_reg;
            job.ack     = mem_rd_data;
        end
    end

    // Drive the info store
    always_comb begin
        mem_req         = '0;
        mem_req.wr_en   = consume && wr_dec;
        mem_req.rd_en   = consume && needs_rd;
        mem_req.addr    = sub;
        mem_req.wr_data = arg_reg;
    end

    // Preamble character expected at the current match count
    always_comb begin
        unique case (pre_cnt_reg)
            2'd1:    pre_char = CH_M;
            default: pre_char = CH_BANG;
        endcase
        if (in_byte_reg == pre_char) begin
            pre_cnt_upd = pre_cnt_reg + 2'd1;
        end else if (pre_cnt_reg != 2'd0) begin
            pre_cnt_upd = (in_byte_reg == CH_BANG) ? 2'd1 : 2'd0;
        end else begin
            pre_cnt_upd = 2'd0;
        end
    end

    // Advance frame and block state on each consumed item
    always_comb begin
        phase_next   = phase_reg;
        pre_cnt_next = pre_cnt_reg;
        cmd_next     = cmd_reg;
        arg_next     = arg_reg;
        reading_next = reading_reg;
        power_next   = power_reg;
        await_next   = await_reg;
        pend_rd_next = consume && needs_rd;
        if (consume) begin
            if (in_flag_reg) begin
                if (await_reg) begin
                    await_next   = 1'b0;
                    reading_next = in_rd_reg;
                end
            end else if (!await_reg) begin
                unique case (phase_reg)
                    PH_HUNT: begin
                        if (pre_cnt_upd == 2'd3) begin
                            pre_cnt_next = 2'd0;
                            phase_next   = PH_CMD;
                        end else begin
                            pre_cnt_next = pre_cnt_upd;
                        end
                    end
                    PH_CMD: begin
                        cmd_next   = in_byte_reg;
                        phase_next = PH_ARG;
                    end
                    PH_ARG: begin
                        arg_next   = in_byte_reg;
                        phase_next = PH_END;
                    end
                    PH_END: begin
                        phase_next   = PH_HUNT;
                        pre_cnt_next = 2'd0;
                        if (frame_end && cmd_reg != CMD_COMMIT) begin
                            if (op == OP_SENSOR && sub <= SENSOR_MAX) begin
                                await_next = 1'b1;
                            end
                            if (op == OP_POWER) begin
                                power_next = power_upd;
                            end
                        end
                    end
                    default: begin
                        phase_next   = PH_HUNT;
                        pre_cnt_next = 2'd0;
                    end
                endcase
            end
        end
    end

    // Load the input register
    assign in_vld_next = s_tready ? s_tvalid : in_vld_reg;

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_flag_reg <= s_tuser[0];
            in_byte_reg <= s_tdata[7:0];
            in_rd_reg   <= s_tdata[17:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            phase_reg   <= PH_HUNT;
            pre_cnt_reg <= 2'd0;
            cmd_reg     <= 8'h00;
            arg_reg     <= 8'h00;
            reading_reg <= 10'd0;
            power_reg   <= 8'h00;
            await_reg   <= 1'b0;
            pend_rd_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            phase_reg   <= phase_next;
            pre_cnt_reg <= pre_cnt_next;
            cmd_reg     <= cmd_next;
            arg_reg     <= arg_next;
            reading_reg <= reading_next;
            power_reg   <= power_next;
            await_reg   <= await_next;
            pend_rd_reg <= pend_rd_next;
        end
    end

    // A pending info read blocks the next item
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_rd_reg |-> !consume)
        else $error("item consumed during pending info read");

    // A pending read follows a consumed info read and yields a job
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_rd_reg |-> ($past(mem_req.rd_en) && job_vld))
        else $error("pending read without issued read or job");

endmodule
`default_nettype wire

// ===== hdl/fcs_resp.sv =====
// Response generator: holds one job and streams its results out.
`timescale 1ns / 1ps
`default_nettype none
module fcs_resp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            job_vld,
    input  wire fcs_pkg::job_t                   job,
    output logic                                 job_rdy,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [fcs_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic [2:0]                           m_tuser,
    output logic                                 m_tlast
);
    import fcs_pkg::*;

    logic       busy_reg, busy_next;
    logic [2:0] step_reg, step_next;
    job_t       job_reg;
    logic       xfer;
    logic       at_last;
    logic       op_step;
    logic [7:0] tx_byte;

    assign op_step = (step_reg == STEP_OP);
    assign at_last = job_reg.ack_vld ? (step_reg == STEP_END) : 1'b1;
    assign xfer    = busy_reg && m_tready;
    assign job_rdy = !busy_reg || (xfer && at_last);

    // Pick the acknowledge byte for the current step
    always_comb begin
        unique case (step_reg)
            STEP_SYNC: tx_byte = CH_BANG;
            STEP_S:    tx_byte = CH_S;
            STEP_BANG: tx_byte = CH_BANG;
            STEP_CMD:  tx_byte = job_reg.cmd;
            STEP_ACK:  tx_byte = job_reg.ack;
            STEP_END:  tx_byte = END_MARK;
            default:   tx_byte = 8'h00;
        endcase
    end

    // Advance through the job, load the next one when done
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (xfer) begin
            if (at_last) begin
                busy_next = 1'b0;
            end else begin
                step_next = step_reg + 3'd1;
            end
        end
        if (job_vld) begin
            busy_next = 1'b1;
            step_next = job.op_vld ? STEP_OP : STEP_SYNC;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_vld) begin
            job_reg <= job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= STEP_OP;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Present the current result
    assign m_tvalid = busy_reg;
    assign m_tlast  = at_last;
    assign m_tuser  = op_step ? job_reg.op_kind : KIND_TX;
    assign m_tdata  = op_step
        ? {2'b00, job_reg.sel, job_reg.pwr, job_reg.word, job_reg.unit, 8'h00}
        : {32'h0, tx_byte};

    // Jobs arrive only when the generator can take them
    assert property (@(posedge aclk) disable iff (!aresetn)
        job_vld |-> job_rdy)
        else $error("job issued while response generator busy");

    // Step stays inside the response
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (step_reg <= STEP_END))
        else $error("response step out of range");

endmodule
`default_nettype wire

// ===== test/framed_command_slave_top_tb.sv =====
// Self-checking testbench: framed link bytes in, predicted operation results and acks checked.
`timescale 1ns / 1ps
module framed_command_slave_top_tb;
    import fcs_pkg::*;

    // Input transaction kinds carried on s_tuser
    localparam logic CMD_LINK    = 1'b0;
    localparam logic CMD_READING = 1'b1;

    // Frame phases
    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_CMD  = 2'd1;
    localparam logic [1:0] PH_ARG  = 2'd2;
    localparam logic [1:0] PH_END  = 2'd3;

    localparam int RANDOM_ITEMS = 128;
    localparam int QUIET_AFTER  = 100;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [2:0]  unit;
        logic [15:0] word;
        logic [7:0]  pwr;
        logic [2:0]  sel;
        logic        last;
    } response_t;

    // Frame interpreter mirror plus the queue of responses it has promised
    class response_board;
        logic [1:0] match_count;
        logic [1:0] phase;
        logic [7:0] cmd_q;
        logic [7:0] arg_q;
        logic [9:0] reading;
        logic [7:0] info [INFO_BYTES];
        logic [7:0] image [INFO_BYTES];
        logic [7:0] pwr;
        bit         waiting;
        response_t  due[$];
        response_t  batch[$];
        int         errors;

        function void clear();
            match_count = 2'd0;
            phase       = PH_HUNT;
            cmd_q       = 8'h00;
            arg_q       = 8'h00;
            reading     = 10'h000;
            pwr         = 8'h00;
            waiting     = 1'b0;
            foreach (info[i]) info[i] = 8'h00;
            info[9]  = 8'h82;
            info[12] = 8'h02;
            info[14] = 8'h12;
            info[15] = 8'h34;
            foreach (image[i]) image[i] = info[i];
            due.delete();
            batch.delete();
            errors    = 0;
        endfunction

        function void add(kind_t k, logic [7:0] d, logic [2:0] u, logic [15:0] w,
                          logic [7:0] p, logic [2:0] s);
            response_t r;
            r.kind = k;
            r.data = d;
            r.unit = u;
            r.word = w;
            r.pwr  = p;
            r.sel  = s;
            r.last = 1'b0;
            batch.push_back(r);
        endfunction

        // Six-byte acknowledge echoing the command byte
        function void add_ack(logic [7:0] ack);
            add(KIND_TX, CH_BANG, 3'd0, 16'h0, 8'h0, 3'd0);
            add(KIND_TX, CH_S, 3'd0, 16'h0, 8'h0, 3'd0);
            add(KIND_TX, CH_BANG, 3'd0, 16'h0, 8'h0, 3'd0);
            add(KIND_TX, cmd_q, 3'd0, 16'h0, 8'h0, 3'd0);
            add(KIND_TX, ack, 3'd0, 16'h0, 8'h0, 3'd0);
            add(KIND_TX, END_MARK, 3'd0, 16'h0, 8'h0, 3'd0);
        endfunction

        function void run_command();
            logic [3:0] idx;
            idx = cmd_q[3:0];
            if (cmd_q == CMD_COMMIT) begin
                foreach (image[i]) image[i] = info[i];
                add(KIND_COMMIT, 8'h0, 3'd0, 16'h0, 8'h0, 3'd0);
                add_ack(8'h00);
            end else begin
                case (cmd_q[7:6])
                    OP_ATTEN: begin
                        add(KIND_ATTEN, 8'h0, cmd_q[2:0], ATTEN_MARK | {8'h00, arg_q},
                            8'h0, 3'd0);
                        add_ack(8'h00);
                    end
                    OP_SENSOR: begin
                        if (idx > SENSOR_MAX) begin
                            add_ack({6'b0, reading[1:0]});
                        end else begin
                            waiting = 1'b1;
                            add(KIND_SAMPLE, 8'h0, 3'd0, 16'h0, 8'h0, idx[2:0]);
                        end
                    end
                    OP_INFO: begin
                        if (cmd_q[4] && idx < WRITABLE_BYTES) info[idx] = arg_q;
                        add_ack(info[idx]);
                    end
                    default: begin
                        pwr[cmd_q[2:0]] = (arg_q != 8'h00);
                        add(KIND_POWER, 8'h0, 3'd0, 16'h0, pwr, 3'd0);
                        add_ack(8'h00);
                    end
                endcase
            end
        endfunction

        function void take_link_byte(logic [7:0] b);
            case (phase)
                PH_HUNT: begin
                    // A broken partial match rechecks this byte as a fresh start
                    if (b == ((match_count == 2'd1) ? CH_M : CH_BANG))
                        match_count = match_count + 2'd1;
                    else if (match_count != 2'd0)
                        match_count = (b == CH_BANG) ? 2'd1 : 2'd0;
                    if (match_count == 2'd3) begin
                        match_count = 2'd0;
                        phase       = PH_CMD;
                    end
                end
                PH_CMD: begin
                    cmd_q = b;
                    phase = PH_ARG;
                end
                PH_ARG: begin
                    arg_q = b;
                    phase = PH_END;
                end
                default: begin
                    phase       = PH_HUNT;
                    match_count = 2'd0;
                    if (b == END_MARK) run_command();
                end
            endcase
        endfunction

        // Note one accepted input transaction and queue what it causes
        function void take_input(logic cmd, logic [7:0] rx, logic [9:0] rd);
            response_t r;
            batch.delete();
            if (cmd == CMD_READING) begin
                if (waiting) begin
                    waiting = 1'b0;
                    reading = rd;
                    add_ack(rd[9:2]);
                end
            end else if (!waiting) begin
                take_link_byte(rx);
            end
            foreach (batch[i]) begin
                r      = batch[i];
                r.last = (i == batch.size() - 1);
                due.push_back(r);
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task match_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        // Compare one accepted result transaction with the oldest promise
        task check_response(logic [M_TDATA_W-1:0] tdata, logic [2:0] tuser,
                            logic tlast);
            response_t r;
            if (due.size() == 0) begin
                report_mismatch($sformatf("result with none due, tdata %h tuser %0d",
                                          tdata, tuser));
                return;
            end
            r = due.pop_front();
            match_field("kind", 16'(tuser), 16'(r.kind));
            match_field("data_byte", 16'(tdata[7:0]), 16'(r.data));
            match_field("unit_index", 16'(tdata[10:8]), 16'(r.unit));
            match_field("attenuator_word", tdata[26:11], r.word);
            match_field("power_bits", 16'(tdata[34:27]), 16'(r.pwr));
            match_field("sensor_select", 16'(tdata[37:35]), 16'(r.sel));
            match_field("last", 16'(tlast), 16'(r.last));
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [2:0]           m_tuser;
    logic                 m_tlast;

    response_board board;
    bit            src_gaps_on;
    bit            sink_stalls_on;
    int            items_sent;
    int            stall_left;
    int            cycle_count;

    framed_command_slave_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Stall the result channel in random bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
        end else if (sink_stalls_on && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 14);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check results; values at the falling edge hold through the next rising edge
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_response(m_tdata, m_tuser, m_tlast);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Drive one input transaction, optionally after an idle burst
    task automatic push_item(input logic cmd, input logic [7:0] rx, input logic [9:0] rd);
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, rd, rx};
        s_tuser  <= cmd;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        board.take_input(cmd, rx, rd);
        items_sent++;
        @(posedge aclk);
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] arg,
                              input logic [7:0] end_byte);
        push_item(CMD_LINK, CH_BANG, 10'($urandom_range(0, 1023)));
        push_item(CMD_LINK, CH_M, 10'($urandom_range(0, 1023)));
        push_item(CMD_LINK, CH_BANG, 10'($urandom_range(0, 1023)));
        push_item(CMD_LINK, cmd, 10'($urandom_range(0, 1023)));
        push_item(CMD_LINK, arg, 10'($urandom_range(0, 1023)));
        push_item(CMD_LINK, end_byte, 10'($urandom_range(0, 1023)));
    endtask

    // One unit of random traffic: mostly good frames, some noise and broken frames
    task automatic send_random_unit();
        int         pick;
        logic [7:0] cmd;
        logic [7:0] arg;
        logic [5:0] low6;
        logic [1:0] mid2;
        logic [3:0] code;
        pick = $urandom_range(0, 9);
        low6 = 6'($urandom_range(0, 63));
        mid2 = 2'($urandom_range(0, 3));
        code = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15))
                                           : 4'($urandom_range(0, 4));
        if (pick == 0) begin
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 3) == 0)
                    push_item(CMD_READING, 8'($urandom_range(0, 255)),
                              10'($urandom_range(0, 1023)));
                else
                    push_item(CMD_LINK, 8'($urandom_range(0, 255)),
                              10'($urandom_range(0, 1023)));
            end
        end else if (pick == 1) begin
            if ($urandom_range(0, 1) == 1) begin
                push_item(CMD_LINK, CH_BANG, 10'($urandom_range(0, 1023)));
                push_item(CMD_LINK, CH_M, 10'($urandom_range(0, 1023)));
                push_item(CMD_LINK, 8'($urandom_range(0, 255)),
                          10'($urandom_range(0, 1023)));
            end else begin
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 254)));
            end
        end else begin
            case ($urandom_range(0, 8))
                0:       cmd = CMD_COMMIT;
                1, 2:    cmd = {OP_ATTEN, low6};
                3, 4:    cmd = {OP_SENSOR, mid2, code};
                5, 6:    cmd = {OP_INFO, low6};
                default: cmd = {OP_POWER, low6};
            endcase
            arg = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            send_frame(cmd, arg, END_MARK);
        end
        // Answer a pending conversion, sometimes after a byte that gets dropped
        if (board.waiting) begin
            if ($urandom_range(0, 2) == 0)
                push_item(CMD_LINK, 8'($urandom_range(0, 255)),
                          10'($urandom_range(0, 1023)));
            push_item(CMD_READING, 8'($urandom_range(0, 255)),
                      10'($urandom_range(0, 1023)));
        end
    endtask

    initial begin
        int start_count;
        board = new;
        board.clear();
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        m_tready    <= 1'b0;
        aresetn     <= 1'b0;
        cycle_count <= 0;
        stall_left     = 0;
        items_sent     = 0;
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: unrequested reading, restart on a repeated bang,
        // sensor request with a dropped byte, then an image commit
        push_item(CMD_READING, 8'h00, 10'h000);
        push_item(CMD_LINK, CH_BANG, 10'h3FF);
        send_frame(8'h07, 8'hFF, END_MARK);
        send_frame({OP_SENSOR, 6'h04}, 8'h00, END_MARK);
        push_item(CMD_LINK, 8'hFF, 10'h000);
        push_item(CMD_READING, 8'h00, 10'h3FF);
        send_frame(CMD_COMMIT, 8'h00, END_MARK);

        // Random traffic, with the idle bursts dropped toward the end
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            if (items_sent - start_count >= QUIET_AFTER) begin
                src_gaps_on    = 1'b0;
                sink_stalls_on = 1'b0;
            end
            send_random_unit();
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results
        while (board.due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/fcs_pkg.sv
hdl/fcs_info_mem.sv
hdl/fcs_ctrl.sv
hdl/fcs_resp.sv
hdl/framed_command_slave_top.sv
test/framed_command_slave_top_tb.sv
